>>> rtl/fdec_pkg.sv
// Shared types, constants and coefficient table for the 2:1 decimating FIR.
// No dependencies; imported by fir_decimate_by_two_core.
package fdec_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = 36;
    localparam int FRAC_BITS   = 15;
    localparam int COEF_COUNT  = 31;
    localparam int COEF_IDX_W  = 6;
    localparam int SHIFTED_W   = ACC_W - FRAC_BITS;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_BITS - 1));

    localparam logic signed [COEF_W-1:0] LOWPASS_Q15 [COEF_COUNT] = '{
        -16'sd9,    16'sd65,    16'sd33,    -16'sd132,  -16'sd112,  16'sd261,
        16'sd305,   -16'sd438,  -16'sd691,  16'sd635,   16'sd1429,  -16'sd813,
        -16'sd3041, 16'sd937,   16'sd10266, 16'sd15378, 16'sd10266, 16'sd937,
        -16'sd3041, -16'sd813,  16'sd1429,  16'sd635,   -16'sd691,  -16'sd438,
        16'sd305,   16'sd261,   -16'sd112,  -16'sd132,  16'sd33,    16'sd65,
        -16'sd9
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH
    } fdec_state_t;

    // Taps beyond the table get a zero coefficient.
    function automatic logic signed [COEF_W-1:0] coef_at(input logic [COEF_IDX_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (idx < COEF_IDX_W'(COEF_COUNT)) begin
            c = LOWPASS_Q15[idx[4:0]];
        end
        return c;
    endfunction

endpackage

>>> rtl/fdec_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fdec_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 31
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/fir_decimate_by_two_core.sv
// Top level of the 2:1 decimating 31-tap Q15 low-pass FIR.
// Depends on fdec_pkg (types, coefficients) and fdec_ram (delay line storage).

// One signed 16-bit sample per input item goes into a circular delay line of
// TAP_COUNT entries held in a RAM. Every other item (the first after reset,
// then every second one) produces one output item: the delay line, newest
// first, is run through a single shared 16x16 multiplier and a 36-bit
// accumulator, one tap per cycle, then rounded (+2^14), shifted right by 15
// and saturated to 16 bits. A non-emitting item is taken with s_tready
// staying high. An emitting item holds s_tready low while the block makes
// TAP_COUNT read/multiply issues, drains the RAM-read and multiply
// registers, then rounds and loads the output register, a stretch set by
// the one RAM read port and the one multiplier. The result sits in an output
// register, so the next item is taken while it waits; if an earlier result
// is still untaken when a new one finishes, the block holds in its final
// step until m_tready frees the register. No clearing pass follows reset:
// a fill count marks which delay-line entries were written since reset, and
// unwritten entries read as the first sample.
module fir_decimate_by_two_core
    import fdec_pkg::*;
#(
    parameter int TAP_COUNT = 31
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input items
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [15:0] sample_in
    // result items
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata    // [15:0] sample_out
);

    localparam int PTR_W  = $clog2(TAP_COUNT);
    localparam int FILL_W = $clog2(TAP_COUNT + 1);

    typedef struct packed {
        logic ready;    // idle, item may be taken
        logic issue;    // one tap read/coefficient issue this cycle
        logic finish;   // rounding result loads the output register
    } fdec_ctrl_t;

    fdec_state_t state_reg, state_next;
    fdec_ctrl_t  ctrl;

    logic                        s_accept;
    logic                        emit;

    logic [PTR_W-1:0]            wr_ptr_reg;
    logic [PTR_W-1:0]            rd_ptr_reg;
    logic [PTR_W-1:0]            tap_cnt_reg;
    logic [FILL_W-1:0]           fill_cnt_reg;
    logic                        skip_phase_reg;
    logic signed [SAMPLE_W-1:0]  first_reg;

    // MAC pipeline
    logic                        v1_reg, v2_reg;
    logic                        use_first_reg;
    logic signed [COEF_W-1:0]    coef_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic [SAMPLE_W-1:0]         ram_rdata;
    logic signed [SAMPLE_W-1:0]  operand;

    // output stage
    logic                        m_tvalid_reg;
    logic [SAMPLE_W-1:0]         m_tdata_reg;
    logic                        out_free;
    logic signed [ACC_W-1:0]     rounded;
    logic signed [SHIFTED_W-1:0] shifted;
    logic [SAMPLE_W-1:0]         saturated;
    logic                        fits;

    assign s_accept = s_tvalid && ctrl.ready;
    assign emit     = !skip_phase_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // delay line storage; written on the accept edge
    fdec_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAP_COUNT)
    ) u_hist (
        .aclk  (aclk),
        .we    (s_accept),
        .waddr (wr_ptr_reg),
        .wdata (s_tdata),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && emit) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (tap_cnt_reg == PTR_W'(TAP_COUNT - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:   ctrl.ready  = 1'b1;
            ST_MAC:    ctrl.issue  = 1'b1;
            ST_DRAIN:  ctrl = '0;
            ST_FINISH: ctrl.finish = out_free;
            default:   ctrl = '0;
        endcase
    end

    // entries not yet written since reset read as the first sample
    assign operand = use_first_reg ? first_reg : $signed(ram_rdata);

    // round half up, floor shift, saturate
    assign rounded   = acc_reg + ROUND_BIAS;
    assign shifted   = SHIFTED_W'(rounded >>> FRAC_BITS);
    assign fits      = (shifted[SHIFTED_W-1:SAMPLE_W-1] == '0) ||
                       (shifted[SHIFTED_W-1:SAMPLE_W-1] == '1);
    always_comb begin
        if (fits) begin
            saturated = shifted[SAMPLE_W-1:0];
        end else if (shifted[SHIFTED_W-1]) begin
            saturated = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            saturated = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wr_ptr_reg     <= '0;
            fill_cnt_reg   <= '0;
            skip_phase_reg <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= ctrl.issue;
            v2_reg    <= v1_reg;
            if (s_accept) begin
                skip_phase_reg <= !skip_phase_reg;
                wr_ptr_reg     <= (wr_ptr_reg == PTR_W'(TAP_COUNT - 1)) ?
                                  '0 : wr_ptr_reg + 1'b1;
                if (fill_cnt_reg != FILL_W'(TAP_COUNT)) begin
                    fill_cnt_reg <= fill_cnt_reg + 1'b1;
                end
            end
            if (ctrl.finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_ptr_reg  <= wr_ptr_reg;
            tap_cnt_reg <= '0;
            acc_reg     <= '0;
            if (fill_cnt_reg == '0) begin
                first_reg <= $signed(s_tdata);
            end
        end
        if (ctrl.issue) begin
            rd_ptr_reg    <= (rd_ptr_reg == '0) ? PTR_W'(TAP_COUNT - 1) : rd_ptr_reg - 1'b1;
            tap_cnt_reg   <= tap_cnt_reg + 1'b1;
            coef_reg      <= coef_at(COEF_IDX_W'(tap_cnt_reg));
            use_first_reg <= (FILL_W'(rd_ptr_reg) >= fill_cnt_reg);
        end
        if (v1_reg) begin
            prod_reg <= operand * coef_reg;
        end
        if (v2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (ctrl.finish) begin
            m_tdata_reg <= saturated;
        end
    end

    assign s_tready = ctrl.ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/fdec_checker.sv
// Port-level checks for fir_decimate_by_two_core, bound to the top level.
// No package dependencies.
module fdec_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a new result only appears after a busy stretch
    a_rise_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without computation");

    // of two back-to-back items the second is an emitting one
    a_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc ##1 s_acc |=> !s_tready)
        else $error("emitting phase did not start a computation");

endmodule

bind fir_decimate_by_two_core fdec_checker u_fdec_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for fir_decimate_by_two_core, the 2:1 decimating low-pass FIR.
// Needs only the RTL. Items go in through a queue-fed driver, and a monitor checks each
// output item against a cycle-free software model of the filter.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS      = 31;
    localparam int NUM_COEFS = 31;
    localparam int RAND_ITEMS = 820;

    // Q15 low-pass taps, newest sample first (symmetric)
    localparam logic signed [15:0] LP_TAPS [NUM_COEFS] = '{
        -16'sd9,    16'sd65,    16'sd33,    -16'sd132,  -16'sd112,  16'sd261,
        16'sd305,   -16'sd438,  -16'sd691,  16'sd635,   16'sd1429,  -16'sd813,
        -16'sd3041, 16'sd937,   16'sd10266, 16'sd15378, 16'sd10266, 16'sd937,
        -16'sd3041, -16'sd813,  16'sd1429,  16'sd635,   -16'sd691,  -16'sd438,
        16'sd305,   16'sd261,   -16'sd112,  -16'sd132,  16'sd33,    16'sd65,
        -16'sd9
    };

    localparam logic signed [15:0] FULL_POS = 16'sh7fff;
    localparam logic signed [15:0] FULL_NEG = 16'sh8000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [15:0] sample_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [15:0] sample_out

    fir_decimate_by_two_core #(.TAP_COUNT(TAPS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------
    // Filter model state
    // ------------------------------------------------------------------
    logic signed [15:0] delay_line [TAPS];
    int unsigned        wr_pos      = 0;
    bit                 line_filled = 1'b0;
    bit                 odd_phase   = 1'b0;   // set: next sample produces nothing

    logic [15:0]        pending_q [$];        // samples waiting for the driver
    logic signed [15:0] filtered_q [$];       // predicted output samples, oldest first
    int                 mismatch_count = 0;
    int                 queued_count   = 0;

    // Advance the filter by one input sample; returns 1 when an output is due.
    function automatic bit fir_predict(input logic signed [15:0] smp,
                                       output logic signed [15:0] y);
        logic signed [47:0] acc;
        logic signed [47:0] shifted;
        int unsigned        p;
        bit                 emit;
        acc = '0;
        if (!line_filled) begin
            for (int i = 0; i < TAPS; i++) delay_line[i] = smp;
            line_filled = 1'b1;
        end
        delay_line[wr_pos] = smp;
        p = wr_pos;
        wr_pos = (wr_pos + 1 >= TAPS) ? 0 : wr_pos + 1;
        emit = !odd_phase;
        odd_phase = !odd_phase;
        y = '0;
        if (emit) begin
            for (int t = 0; t < TAPS; t++) begin
                if (t < NUM_COEFS) acc += delay_line[p] * LP_TAPS[t];
                p = (p == 0) ? TAPS - 1 : p - 1;
            end
            shifted = (acc + 48'sd16384) >>> 15;   // round, then floor shift
            if (shifted > 48'sd32767)       y = FULL_POS;
            else if (shifted < -48'sd32768) y = FULL_NEG;
            else                            y = shifted[15:0];
        end
        return emit;
    endfunction

    task automatic push_sample(input logic [15:0] v);
        pending_q.push_back(v);
        queued_count++;
    endtask

    // Samples that line up with the tap signs so the sum runs past full scale.
    // Padded so that the last sample of the pattern lands on an emitting phase.
    task automatic push_overload(input bit negative);
        logic signed [15:0] v;
        if ((queued_count + TAPS - 1) % 2 != 0) push_sample(16'($urandom_range(0, 65535)));
        for (int i = 0; i < TAPS; i++) begin
            v = ((LP_TAPS[i % NUM_COEFS] >= 0) ^ negative) ? FULL_POS : FULL_NEG;
            push_sample(v);
        end
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Input driver: one item at a time from pending_q, random gaps
    // ------------------------------------------------------------------
    int unsigned in_gap  = 0;
    bit          in_calm = 1'b0;   // stretch with no gaps

    always @(posedge aclk) begin
        logic        vld_n;
        logic [15:0] dat_n;
        logic signed [15:0] y;
        int unsigned gap_n;
        vld_n = s_tvalid;
        dat_n = s_tdata;
        gap_n = in_gap;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                if (fir_predict($signed(s_tdata), y)) filtered_q.push_back(y);
                vld_n = 1'b0;
            end
            if (!vld_n) begin
                if (gap_n > 0) begin
                    gap_n--;
                end else if (pending_q.size() != 0) begin
                    dat_n = pending_q.pop_front();
                    vld_n = 1'b1;
                    if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
                    gap_n = in_calm ? 0 : $urandom_range(0, 4);
                end
            end
        end
        s_tvalid <= vld_n;
        s_tdata  <= dat_n;
        in_gap   <= gap_n;
    end

    // ------------------------------------------------------------------
    // Output monitor: random back-pressure, checks against filtered_q
    // ------------------------------------------------------------------
    int unsigned out_stall = 0;
    bit          out_calm  = 1'b0;

    always @(posedge aclk) begin
        logic               rdy_n;
        logic signed [15:0] want;
        int unsigned        stall_n;
        rdy_n   = m_tready;
        stall_n = out_stall;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t: unexpected output item, got %0d", $time, $signed(m_tdata));
                    mismatch_count++;
                end else begin
                    want = filtered_q.pop_front();
                    if ($signed(m_tdata) !== want) begin
                        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                                 $time, want, $signed(m_tdata));
                        mismatch_count++;
                    end
                end
                if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
                stall_n = out_calm ? 0 : $urandom_range(0, 4);
            end
            if (stall_n > 0) begin
                stall_n--;
                rdy_n = 1'b0;
            end else begin
                rdy_n = 1'b1;
            end
        end
        m_tready  <= rdy_n;
        out_stall <= stall_n;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int          kind;
        int unsigned len;
        int          rand_start;
        logic [15:0] level;

        // Directed: first sample primes the whole line with negative full scale,
        // then steps between the extremes, zero and small values.
        push_sample(FULL_NEG);
        push_sample(FULL_NEG);
        push_sample(FULL_POS);
        push_sample(FULL_POS);
        push_sample(FULL_POS);
        push_sample(16'h0000);
        push_sample(16'hffff);
        push_sample(16'h0001);
        push_sample(16'haaaa);
        push_sample(16'h5555);
        for (int i = 0; i < 10; i++) push_sample(i[0] ? FULL_NEG : FULL_POS);
        push_sample(16'h0000);
        push_sample(16'h0000);

        // Random part: mix of noise, quiet signals, constant-level runs, overload and a Nyquist-rate tone
        rand_start = queued_count;
        while (queued_count - rand_start < RAND_ITEMS) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(4, 40);
            case (kind)
                0, 1, 2: begin
                    for (int i = 0; i < len; i++) push_sample(16'($urandom_range(0, 65535)));
                end
                3, 4: begin
                    for (int i = 0; i < len; i++)
                        push_sample(16'(int'($urandom_range(0, 511)) - 256));
                end
                5, 6: begin
                    push_overload(1'($urandom_range(0, 1)));
                end
                7: begin
                    case ($urandom_range(0, 3))
                        0:       level = FULL_POS;
                        1:       level = FULL_NEG;
                        2:       level = 16'h0000;
                        default: level = 16'hffff;
                    endcase
                    for (int i = 0; i < len; i++) push_sample(level);
                end
                default: begin
                    // Nyquist-rate tone, should be strongly attenuated
                    for (int i = 0; i < len; i++) push_sample(i[0] ? FULL_NEG : FULL_POS);
                end
            endcase
        end

        @(posedge aclk);
        while (pending_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (filtered_q.size() != 0) @(posedge aclk);
        repeat (TAPS * 2 + 20) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Generous ceiling: every item emitting, full gaps and stalls, several times over
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
